FILE: hdl/bfbd_pkg.sv
// ----------------------------------------------------------------------------
// bfbd_pkg
// types and constants shared by the blink frequency band detector
// ----------------------------------------------------------------------------
package bfbd_pkg;

  // one frame sample
  typedef struct packed {
    logic [15:0] intensity;
    logic [31:0] timestamp_ms;
  } sample_t;

  // one detection result
  typedef struct packed {
    logic        detected;
    logic        window_full;
    logic [15:0] frequency_q8;
    logic [5:0]  peak_count;
  } result_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LOW_FREQ  = 2'd0,
    REG_HIGH_FREQ = 2'd1
  } reg_index_t;

  localparam logic [15:0] LOW_FREQ_RESET  = 16'd1280;
  localparam logic [15:0] HIGH_FREQ_RESET = 16'd2048;

  // 1000 ms per second times 256 for q8.8
  localparam int FREQ_SCALE = 256000;
  localparam int SCALE_W    = 18;
  localparam int PEAK_OUT_MAX = 63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_SAT,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/bfbd_divider.sv
// ----------------------------------------------------------------------------
// bfbd_divider
// restoring divider, one quotient bit per cycle, 32-bit divisor
// ----------------------------------------------------------------------------
module bfbd_divider #(
  parameter int NUM_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numerator,
  input  logic [31:0]      divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [31:0]      rem;
  logic [31:0]      den;
  logic [NUM_W-1:0] quo;
  logic [32:0]      rem_sh;
  logic [32:0]      rem_sub;
  logic             q_bit;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    rem_sh  = {rem, quo[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den};
    q_bit   = (rem_sh >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      quo <= numerator;
    end else if (busy) begin
      rem <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
      quo <= {quo[NUM_W-2:0], q_bit};
    end
  end

  assign quotient = quo;

endmodule

FILE: hdl/blink_frequency_band_detector.sv
// ----------------------------------------------------------------------------
// blink_frequency_band_detector
// peak interval frequency estimate over a sliding window of frame samples
// ----------------------------------------------------------------------------
// usage
// - sample channel (sample_valid / sample_stall / sample) carries one frame
//   intensity and its millisecond timestamp per transfer
// - result channel (result_valid / result_stall / result) returns exactly one
//   result per sample transfer, in order
// - cfg_write / cfg_index / cfg_data set the band edges; write only when idle
// - the window lives in one single-port-read sync ram of WINDOW entries
// - while the window is filling, the fsm goes from idle straight to the done
//   state, which loads the output register; once full, scan and prep come
//   first, and divide and saturate when the divider runs: one ram read per
//   window position for the peak scan, then one quotient bit per cycle in
//   the serial divider; idle takes the next sample the cycle after the load
// - one item is in work at a time; sample_stall stays high until the result
//   has moved into the output register
// - a waiting result is held in the output register while result_stall is
//   high, and the next sample may already be taken meanwhile
// - reset (rst, synchronous) empties the window and restores band edges;
//   ram contents are not cleared, the fill count guards them
// ----------------------------------------------------------------------------
module blink_frequency_band_detector #(
  parameter int WINDOW = 100
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  bfbd_pkg::sample_t   sample,
  output logic                result_valid,
  input  logic                result_stall,
  output bfbd_pkg::result_t   result,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int AW = $clog2(WINDOW);       // ram address
  localparam int IW = $clog2(WINDOW + 1);   // counts up to WINDOW
  localparam int PW = $clog2(WINDOW);       // peak count
  localparam int NW = PW + bfbd_pkg::SCALE_W;

  // configuration
  logic [15:0] low_freq_limit;
  logic [15:0] high_freq_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_freq_limit  <= bfbd_pkg::LOW_FREQ_RESET;
      high_freq_limit <= bfbd_pkg::HIGH_FREQ_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bfbd_pkg::REG_LOW_FREQ:  low_freq_limit  <= cfg_data;
        bfbd_pkg::REG_HIGH_FREQ: high_freq_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  bfbd_pkg::state_t state;
  bfbd_pkg::state_t state_next;

  logic          sample_xfer;
  logic          rd_en;
  logic          div_start;
  logic          res_load;
  logic          div_done;
  logic [NW-1:0] div_quo;

  logic [IW-1:0] fill_count;
  logic [IW-1:0] fill_next;
  logic [AW-1:0] write_pointer;
  logic [AW-1:0] wp_next;
  logic          full;

  // scan pipeline
  logic [AW-1:0]       rd_addr;
  logic [IW-1:0]       issued;
  logic                rd_vld;
  logic [AW-1:0]       rd_idx;
  bfbd_pkg::sample_t   rd_data;
  logic [15:0]         prev_int;
  logic [15:0]         cur_int;
  logic [31:0]         cur_time;
  logic [PW-1:0]       peaks;
  logic [31:0]         t_first;
  logic [31:0]         t_last;
  logic [31:0]         span;
  logic                div_go;
  logic [NW-1:0]       numerator;
  logic [15:0]         freq;
  logic [31:0]         peaks_ext;

  assign sample_xfer = sample_valid && !sample_stall;

  // pointer and fill bookkeeping
  always_comb begin
    wp_next   = (write_pointer == AW'(WINDOW - 1)) ? '0 : write_pointer + AW'(1);
    fill_next = (fill_count == IW'(WINDOW)) ? fill_count : fill_count + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      write_pointer <= '0;
    end else if (sample_xfer) begin
      fill_count    <= fill_next;
      write_pointer <= wp_next;
    end
  end

  // window ram: written on sample transfer, read during the scan; the fsm
  // never overlaps the two, so no forwarding is needed
  bfbd_pkg::sample_t mem [WINDOW];

  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      mem[write_pointer] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // divider operands
  always_comb begin
    span      = t_last - t_first;
    div_go    = (peaks >= PW'(2)) && (span != 32'd0);
    numerator = NW'(peaks - PW'(1)) * NW'(bfbd_pkg::FREQ_SCALE);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfbd_pkg::ST_IDLE: begin
        if (sample_xfer) begin
          state_next = (fill_next == IW'(WINDOW)) ? bfbd_pkg::ST_SCAN : bfbd_pkg::ST_DONE;
        end
      end
      bfbd_pkg::ST_SCAN: begin
        // last window position has come back from the ram
        if (rd_vld && rd_idx == AW'(WINDOW - 1)) begin
          state_next = bfbd_pkg::ST_PREP;
        end
      end
      bfbd_pkg::ST_PREP: begin
        state_next = div_go ? bfbd_pkg::ST_DIV : bfbd_pkg::ST_DONE;
      end
      bfbd_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = bfbd_pkg::ST_SAT;
        end
      end
      bfbd_pkg::ST_SAT: begin
        state_next = bfbd_pkg::ST_DONE;
      end
      bfbd_pkg::ST_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = bfbd_pkg::ST_IDLE;
        end
      end
      default: state_next = bfbd_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    sample_stall = 1'b1;
    rd_en        = 1'b0;
    div_start    = 1'b0;
    res_load     = 1'b0;
    unique case (state)
      bfbd_pkg::ST_IDLE: sample_stall = 1'b0;
      bfbd_pkg::ST_SCAN: rd_en = (issued != IW'(WINDOW));
      bfbd_pkg::ST_PREP: div_start = div_go;
      bfbd_pkg::ST_DONE: res_load = !result_valid || !result_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read address walks the window oldest first
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      issued <= '0;
    end else begin
      rd_vld <= rd_en;
      if (sample_xfer) begin
        issued <= '0;
      end else if (rd_en) begin
        issued <= issued + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      rd_addr <= wp_next;
    end else if (rd_en) begin
      rd_addr <= (rd_addr == AW'(WINDOW - 1)) ? '0 : rd_addr + AW'(1);
    end
    if (rd_en) begin
      rd_idx <= issued[AW-1:0];
    end
  end

  // peak search over returning ram data
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      peaks   <= '0;
      t_first <= '0;
      t_last  <= '0;
      full    <= (fill_next == IW'(WINDOW));
    end else if (rd_vld) begin
      prev_int <= cur_int;
      cur_int  <= rd_data.intensity;
      cur_time <= rd_data.timestamp_ms;
      // strict local maximum at the previous position
      if (rd_idx >= AW'(2) && cur_int > prev_int && cur_int > rd_data.intensity) begin
        if (peaks == '0) begin
          t_first <= cur_time;
        end
        t_last <= cur_time;
        peaks  <= peaks + PW'(1);
      end
    end
  end

  // frequency, zero unless the divider ran
  always_ff @(posedge clk) begin
    if (sample_xfer) begin
      freq <= '0;
    end else if (state == bfbd_pkg::ST_SAT) begin
      freq <= (|div_quo[NW-1:16]) ? 16'hffff : div_quo[15:0];
    end
  end

  bfbd_divider #(
    .NUM_W (NW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (numerator),
    .divisor   (span),
    .done      (div_done),
    .quotient  (div_quo)
  );

  // output register
  assign peaks_ext = 32'(peaks);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.window_full  <= full;
      result.frequency_q8 <= freq;
      result.detected     <= full && (freq >= low_freq_limit) && (freq <= high_freq_limit);
      result.peak_count   <= (peaks_ext > 32'(bfbd_pkg::PEAK_OUT_MAX))
                             ? 6'(bfbd_pkg::PEAK_OUT_MAX) : 6'(peaks_ext);
    end
  end

  // checks
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == bfbd_pkg::ST_DONE))
    else $error("result appeared outside the done state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == bfbd_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= IW'(WINDOW))
    else $error("fill count beyond window size");

  a_not_full_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.window_full) |->
      (result.frequency_q8 == 16'd0 && result.peak_count == 6'd0 && !result.detected))
    else $error("nonzero result while window not full");

endmodule

FILE: test/tb_blink_frequency_band_detector.sv
// ----------------------------------------------------------------------------
// tb_blink_frequency_band_detector
// self-checking bench for the blink frequency band detector
// ----------------------------------------------------------------------------
// frame samples go in over the valid/stall sample channel, and every result
// transfer is compared field by field with an in-bench model of the sliding
// window, the strict-peak scan and the q8.8 frequency estimate. a short table
// of fill-phase samples with known results comes first. bursts of blink-like,
// flat, single-peak, frozen-clock, saturating, wrapping and noisy sequences
// follow, each after the first under a band setting written while the block is idle
// ----------------------------------------------------------------------------
module tb_blink_frequency_band_detector;

  localparam int WIN = 100;
  localparam int N_ITEMS = 1250;
  localparam int FILL_ROWS = 24;
  // 1000 ms per second times 256 for q8.8
  localparam longint unsigned MS_Q8 = 64'd256000;
  // the worst gap between transfers is one full-window item with random idle
  // gaps on both channels plus the long receiver hold; the limit is several times that
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_REPORTS = 60;
  // register indexes past the two band edges, written to show they are ignored
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {
    PAT_BLINK,
    PAT_FLAT,
    PAT_SINGLE,
    PAT_FROZEN,
    PAT_FAST,
    PAT_NOISE,
    PAT_WRAP
  } pattern_e;

  typedef struct {
    bfbd_pkg::sample_t s;
    bfbd_pkg::result_t want;
  } fill_row_t;

  // while the window is still filling every field of the result is zero
  localparam bfbd_pkg::result_t FILLING = '{detected: 1'b0, window_full: 1'b0,
                                            frequency_q8: 16'd0, peak_count: 6'd0};

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // block ports
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  bfbd_pkg::sample_t frame_in = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  bfbd_pkg::result_t verdict_out;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  blink_frequency_band_detector #(
    .WINDOW(WIN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(frame_in),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(verdict_out),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // bench copy of the window, fill state and band edges
  logic [15:0] lum_ring [WIN];
  logic [31:0] stamp_ring [WIN];
  int          held = 0;
  int          next_slot = 0;
  logic [15:0] band_lo = bfbd_pkg::LOW_FREQ_RESET;
  logic [15:0] band_hi = bfbd_pkg::HIGH_FREQ_RESET;

  bfbd_pkg::result_t pending_q [$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          sent = 0;
  int          quiet = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  logic [31:0] stamp_now = '0;

  // fill phase: extremes and walking patterns on both fields
  fill_row_t fill_table [FILL_ROWS] = '{
    '{{16'h0000, 32'h0000_0000}, FILLING},
    '{{16'hFFFF, 32'hFFFF_FFFF}, FILLING},
    '{{16'h0000, 32'hFFFF_FFFF}, FILLING},
    '{{16'hFFFF, 32'h0000_0000}, FILLING},
    '{{16'h8000, 32'h8000_0000}, FILLING},
    '{{16'h7FFF, 32'h7FFF_FFFF}, FILLING},
    '{{16'h5555, 32'h5555_5555}, FILLING},
    '{{16'hAAAA, 32'hAAAA_AAAA}, FILLING},
    '{{16'h0001, 32'h0000_0001}, FILLING},
    '{{16'hFFFE, 32'hFFFF_FFFE}, FILLING},
    '{{16'h00FF, 32'h0000_FFFF}, FILLING},
    '{{16'hFF00, 32'hFFFF_0000}, FILLING},
    '{{16'h0F0F, 32'h0F0F_0F0F}, FILLING},
    '{{16'hF0F0, 32'hF0F0_F0F0}, FILLING},
    '{{16'h1234, 32'h1234_5678}, FILLING},
    '{{16'h4000, 32'h4000_0000}, FILLING},
    '{{16'hC000, 32'hC000_0000}, FILLING},
    '{{16'h0002, 32'h0000_0021}, FILLING},
    '{{16'h0003, 32'h0000_0042}, FILLING},
    '{{16'h0001, 32'h0000_0063}, FILLING},
    '{{16'h0004, 32'h0000_0084}, FILLING},
    '{{16'h0000, 32'h0000_00A5}, FILLING},
    '{{16'h0005, 32'h0000_00C6}, FILLING},
    '{{16'h0001, 32'h0000_00E7}, FILLING}
  };

  // push one sample into the window and work out the frequency estimate
  function automatic bfbd_pkg::result_t predict_blink(bfbd_pkg::sample_t s);
    bfbd_pkg::result_t r;
    int unsigned     peaks;
    int              pos;
    logic [15:0]     prev_v, cur_v, next_v;
    logic [31:0]     t_first, t_last, span;
    longint unsigned quot;
    logic [15:0]     freq;
    lum_ring[next_slot] = s.intensity;
    stamp_ring[next_slot] = s.timestamp_ms;
    next_slot = (next_slot + 1) % WIN;
    if (held < WIN) held++;
    r = FILLING;
    if (held < WIN) return r;
    // next_slot now points at the oldest sample
    peaks = 0;
    t_first = '0;
    t_last = '0;
    for (pos = 1; pos < WIN - 1; pos++) begin
      prev_v = lum_ring[(next_slot + pos - 1) % WIN];
      cur_v = lum_ring[(next_slot + pos) % WIN];
      next_v = lum_ring[(next_slot + pos + 1) % WIN];
      if (cur_v > prev_v && cur_v > next_v) begin
        if (peaks == 0) t_first = stamp_ring[(next_slot + pos) % WIN];
        t_last = stamp_ring[(next_slot + pos) % WIN];
        peaks++;
      end
    end
    quot = 0;
    if (peaks >= 2) begin
      span = t_last - t_first;
      if (span != 0) quot = (64'(peaks - 1) * MS_Q8) / 64'(span);
    end
    freq = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
    r.window_full = 1'b1;
    r.frequency_q8 = freq;
    r.peak_count = (peaks > 63) ? 6'h3F : 6'(peaks);
    r.detected = (freq >= band_lo) && (freq <= band_hi);
    return r;
  endfunction

  function automatic void set_band(logic [1:0] idx, logic [15:0] val);
    case (idx)
      bfbd_pkg::REG_LOW_FREQ: band_lo = val;
      bfbd_pkg::REG_HIGH_FREQ: band_hi = val;
      default: ;
    endcase
  endfunction

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch %s on result %0d: got 0x%0h, want 0x%0h",
               what, results_seen, got, want);
    mismatches++;
  endtask

  // offer one sample; valid stays high into the next call when there is no gap
  task automatic send_frame(input bfbd_pkg::sample_t s, input bit typed,
                            input bfbd_pkg::result_t want);
    int                gap;
    bfbd_pkg::result_t pred;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    frame_in <= s;
    do @(posedge clk); while (sample_stall);
    pred = predict_blink(s);
    pending_q.insert(pending_q.size(), typed ? want : pred);
    sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic cfg_put(input logic [1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    set_band(idx, val);
  endtask

  // band edges for one phase: fixed extremes first, then random bands
  task automatic apply_band(input int phase);
    logic [15:0] lo, hi;
    int          pick;
    drain();
    pick = 2;
    case (phase)
      1: begin lo = 16'h0000; hi = 16'hFFFF; end         // everything in band
      2: begin lo = 16'h0000; hi = 16'h0000; end         // only zero frequency
      3: begin lo = 16'hFFFF; hi = 16'hFFFF; end         // only saturated
      4: begin lo = bfbd_pkg::HIGH_FREQ_RESET; hi = bfbd_pkg::LOW_FREQ_RESET; end
      5: begin lo = bfbd_pkg::LOW_FREQ_RESET; hi = bfbd_pkg::HIGH_FREQ_RESET; end
      default: begin
        pick = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) begin
          lo = 16'($urandom_range(0, 65535));
          hi = 16'($urandom_range(0, 65535));
        end else begin
          lo = 16'($urandom_range(256, 2560));
          hi = lo + 16'($urandom_range(0, 2560));
        end
      end
    endcase
    // writes to unused indexes must leave the band alone
    if (phase == 1) cfg_put(REG_SPARE_2, 16'hFFFF);
    else if (phase == 2) cfg_put(REG_SPARE_3, 16'hFFFF);
    else if ($urandom_range(0, 3) == 0)
      cfg_put($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
              16'($urandom_range(0, 65535)));
    if (pick != 1) cfg_put(bfbd_pkg::REG_LOW_FREQ, lo);
    if (pick != 0) cfg_put(bfbd_pkg::REG_HIGH_FREQ, hi);
    cfg_write <= 1'b0;
  endtask

  // one burst of samples following a pattern with random content
  task automatic run_burst(input pattern_e kind, input int len);
    int                pf, dt, period_ms, base, rise, ramp, noise_amp, pulse_at, v, k, i;
    logic [15:0]       lo_v, hi_v;
    bit                broken;
    bfbd_pkg::sample_t s;
    // blink: pf frames per blink, dt ms per frame
    pf = $urandom_range(2, 12);
    period_ms = $urandom_range(60, 400);
    dt = period_ms / pf;
    if (dt == 0) dt = 1;
    base = $urandom_range(0, 40000);
    rise = $urandom_range(1, 1500);
    ramp = $urandom_range(0, 60);
    noise_amp = ($urandom_range(0, 2) == 0) ? $urandom_range(1, rise) : 0;
    broken = ($urandom_range(0, 3) == 0);
    hi_v = 16'($urandom_range(1, 65535));
    lo_v = 16'($urandom_range(0, hi_v - 1));
    pulse_at = (len >= 100) ? $urandom_range(len - 90, len - 10) : len / 2;
    // wrap: start just below the top of the ms counter
    if (kind == PAT_WRAP) stamp_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    for (i = 0; i < len; i++) begin
      case (kind)
        PAT_BLINK, PAT_WRAP: begin
          // rise then fall within one blink, single strict maximum
          k = i % pf;
          v = base + rise * ((2 * k < 2 * (pf - k) - 1) ? 2 * k : 2 * (pf - k) - 1);
          if (noise_amp > 0) v += $urandom_range(0, noise_amp);
          stamp_now += dt + $urandom_range(0, dt / 4);
          // broken sequences: glitched frames and dropped frames
          if (broken && $urandom_range(0, 19) == 0) v = $urandom_range(0, 65535);
          if (broken && $urandom_range(0, 29) == 0) stamp_now += $urandom_range(0, 1000);
        end
        PAT_FLAT: begin
          // constant or rising: no peaks
          v = base + i * ramp;
          stamp_now += dt;
        end
        PAT_SINGLE: begin
          v = (i == pulse_at) ? hi_v : lo_v;
          stamp_now += dt;
        end
        PAT_FROZEN: begin
          // every peak at the same time stamp, span of zero
          v = (i % 2) ? hi_v : lo_v;
        end
        PAT_FAST: begin
          // many peaks over a few ms, frequency saturates
          v = (i % 2) ? hi_v : lo_v;
          stamp_now += $urandom_range(0, 1);
        end
        default: begin
          v = $urandom_range(0, 65535);
          stamp_now = $urandom;
        end
      endcase
      s.intensity = (v > 65535) ? 16'hFFFF : v[15:0];
      s.timestamp_ms = stamp_now;
      send_frame(s, 1'b0, FILLING);
    end
  endtask

  // stimulus: fill table, then bursts under changing bands
  initial begin
    int       burst, len, r;
    pattern_e kind;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (fill_table[row]) send_frame(fill_table[row].s, 1'b1, fill_table[row].want);
    stamp_now = fill_table[FILL_ROWS - 1].s.timestamp_ms;
    burst = 0;
    while (sent < N_ITEMS) begin
      if (burst > 0) apply_band(burst);
      calm = ($urandom_range(0, 3) == 0);
      // long receiver hold once the window is full, so the block backs up
      if (burst == 4) hold_req = 1'b1;
      if (burst < 7) begin
        kind = pattern_e'(burst);
      end else begin
        r = $urandom_range(0, 15);
        case (r)
          9: kind = PAT_FLAT;
          10: kind = PAT_SINGLE;
          11: kind = PAT_FROZEN;
          12: kind = PAT_FAST;
          13: kind = PAT_NOISE;
          14, 15: kind = PAT_WRAP;
          default: kind = PAT_BLINK;
        endcase
      end
      case (kind)
        PAT_BLINK: len = $urandom_range(20, 140);
        PAT_NOISE: len = $urandom_range(10, 40);
        default: len = $urandom_range(100, 130);
      endcase
      run_burst(kind, len);
      burst++;
    end
    drain();
    // catch any stray result transfer after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // result side: random stall per result, one long hold on request
  initial begin
    int stall_n;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall_n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall_n = calm ? 0 : $urandom_range(0, 7);
      end
      if (stall_n > 0) begin
        result_stall <= 1'b1;
        repeat (stall_n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    bfbd_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_q.size() == 0) begin
        report("result with nothing pending", verdict_out, 0);
      end else begin
        want = pending_q[0];
        pending_q.delete(0);
        if (verdict_out.detected !== want.detected)
          report("detected", verdict_out.detected, want.detected);
        if (verdict_out.window_full !== want.window_full)
          report("window_full", verdict_out.window_full, want.window_full);
        if (verdict_out.frequency_q8 !== want.frequency_q8)
          report("frequency_q8", verdict_out.frequency_q8, want.frequency_q8);
        if (verdict_out.peak_count !== want.peak_count)
          report("peak_count", verdict_out.peak_count, want.peak_count);
      end
      results_seen++;
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
